>>> rtl/rpr_pkg.sv
// Package for the reprojection residual block: field widths, pipeline depths,
// register indexes and reset values of the intrinsic registers.
// No dependencies.
`default_nettype none

package rpr_pkg;

    localparam int PT_W   = 32;   // Q16.16 points, pixels, residuals
    localparam int QT_W   = 16;   // Q2.14 quaternion
    localparam int K_W    = 24;   // Q16.8 intrinsics
    localparam int CFG_W  = 48;   // widest register
    localparam int IDX_W  = 3;
    localparam int PC_W   = 39;   // camera-space point, Q16, saturated
    localparam int Q_W    = 64;   // projected homogeneous coordinates, Q24
    localparam int QBITS  = 40;   // quotient bits: 24 integer, 16 fraction
    localparam int MAG_W  = QBITS + 1;
    localparam int DIV_LAT = QBITS + 1;

    localparam logic [IDX_W-1:0] REG_INTR_00_01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTR_02_10 = 3'd1;
    localparam logic [IDX_W-1:0] REG_INTR_11_12 = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTR_20_21 = 3'd3;
    localparam logic [IDX_W-1:0] REG_INTR_22    = 3'd4;

    localparam logic [CFG_W-1:0] RST_INTR_00_01 = 48'h0001_0000_0000;
    localparam logic [CFG_W-1:0] RST_INTR_02_10 = 48'h0;
    localparam logic [CFG_W-1:0] RST_INTR_11_12 = 48'h0001_0000_0000;
    localparam logic [CFG_W-1:0] RST_INTR_20_21 = 48'h0;
    localparam logic [K_W-1:0]   RST_INTR_22    = 24'd256;

endpackage

`default_nettype wire

>>> rtl/rpr_div.sv
// Pipelined restoring divider: 64-bit magnitudes in, 16 fraction bits out,
// an input stage, then one quotient bit per stage, clamped to 2^40. Uses rpr_pkg.
`default_nettype none

module rpr_div (
    input  wire logic                       clk,
    input  wire logic [rpr_pkg::Q_W-1:0]    dividend,
    input  wire logic [rpr_pkg::Q_W-1:0]    divisor,
    output logic      [rpr_pkg::MAG_W-1:0]  quotient
);
    import rpr_pkg::*;

    logic [Q_W-1:0]   rem_reg [0:QBITS];
    logic [QBITS-1:0] low_reg [0:QBITS];
    logic [QBITS-1:0] quo_reg [0:QBITS];
    logic [Q_W-1:0]   dvs_reg [0:QBITS];
    logic             ovf_reg [0:QBITS];

    // integer part of 2^24 or more clamps the whole quotient
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {24'd0, dividend[Q_W-1:24]};
        low_reg[0] <= {dividend[23:0], 16'd0};
        quo_reg[0] <= '0;
        dvs_reg[0] <= divisor;
        ovf_reg[0] <= ({24'd0, dividend} >= {divisor, 24'd0});
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_step
        logic [Q_W:0]   trial_next;
        logic [Q_W-1:0] rem_next;
        logic           bit_next;

        always_comb
        begin
            trial_next = {rem_reg[k], low_reg[k][QBITS-1]};
            bit_next   = (trial_next >= {1'b0, dvs_reg[k]});
            if (bit_next)
            begin
                rem_next = Q_W'(trial_next - {1'b0, dvs_reg[k]});
            end
            else
            begin
                rem_next = trial_next[Q_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            low_reg[k+1] <= {low_reg[k][QBITS-2:0], 1'b0};
            quo_reg[k+1] <= {quo_reg[k][QBITS-2:0], bit_next};
            dvs_reg[k+1] <= dvs_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    assign quotient = ovf_reg[QBITS] ? {1'b1, {QBITS{1'b0}}} : {1'b0, quo_reg[QBITS]};

endmodule

`default_nettype wire

>>> rtl/reprojection_residual.sv
// Top level of the pinhole reprojection residual pipeline.
// Uses rpr_pkg and two rpr_div dividers.
//
// Usage:
//   Pulse start with one lidar point, its observed pixel, a Q2.14 pose
//   quaternion and a translation. The item is taken at any edge where start
//   is high and busy is low; busy stays low, so an item may enter every cycle.
//   Each item gives one result: res_u, res_v and zero_depth, shown for one
//   cycle with done high, in the order the items entered.
//   Throughput is one item per cycle. Latency is set by the 9 arithmetic
//   stages (quaternion products, rotation, rotate-translate, intrinsics, abs)
//   plus the 41-stage restoring dividers (an input stage, then one quotient
//   bit per stage), plus the output register.
//   The intrinsic matrix is written through cfg_we/cfg_index/cfg_data by the
//   user, who must do so only while no item is in flight; the block itself
//   does not enforce this. Writes to unknown indexes are dropped.
//   Reset empties the pipeline and loads K as the identity matrix.
//   The receiver cannot stall: results are never held back.
`default_nettype none

module reprojection_residual (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     point_x,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     point_y,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     point_z,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     pixel_u,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     pixel_v,
    input  wire logic signed [rpr_pkg::QT_W-1:0]     quat_x,
    input  wire logic signed [rpr_pkg::QT_W-1:0]     quat_y,
    input  wire logic signed [rpr_pkg::QT_W-1:0]     quat_z,
    input  wire logic signed [rpr_pkg::QT_W-1:0]     quat_w,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     trans_x,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     trans_y,
    input  wire logic signed [rpr_pkg::PT_W-1:0]     trans_z,
    input  wire logic                                cfg_we,
    input  wire logic [rpr_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [rpr_pkg::CFG_W-1:0]           cfg_data,
    output logic                                     done,
    output logic signed [rpr_pkg::PT_W-1:0]          res_u,
    output logic signed [rpr_pkg::PT_W-1:0]          res_v,
    output logic                                     zero_depth
);
    import rpr_pkg::*;

    localparam logic signed [35:0]     ONE_Q28 = 36'sh010000000;
    localparam logic signed [42:0]     PC_MAX  = 43'sh03F_FFFF_FFFF;
    localparam logic signed [42:0]     PC_MIN  = -43'sh040_0000_0000;
    localparam logic signed [MAG_W+1:0] S32_MAX = 43'sh000_7FFF_FFFF;
    localparam logic signed [MAG_W+1:0] S32_MIN = -43'sh000_8000_0000;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] intr_00_01_reg, intr_02_10_reg, intr_11_12_reg, intr_20_21_reg;
    logic [K_W-1:0]   intr_22_reg;
    logic signed [K_W-1:0] kmat [0:2][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intr_00_01_reg <= RST_INTR_00_01;
            intr_02_10_reg <= RST_INTR_02_10;
            intr_11_12_reg <= RST_INTR_11_12;
            intr_20_21_reg <= RST_INTR_20_21;
            intr_22_reg    <= RST_INTR_22;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTR_00_01: intr_00_01_reg <= cfg_data;
                REG_INTR_02_10: intr_02_10_reg <= cfg_data;
                REG_INTR_11_12: intr_11_12_reg <= cfg_data;
                REG_INTR_20_21: intr_20_21_reg <= cfg_data;
                REG_INTR_22:    intr_22_reg    <= cfg_data[K_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        kmat[0][0] = $signed(intr_00_01_reg[47:24]);
        kmat[0][1] = $signed(intr_00_01_reg[23:0]);
        kmat[0][2] = $signed(intr_02_10_reg[47:24]);
        kmat[1][0] = $signed(intr_02_10_reg[23:0]);
        kmat[1][1] = $signed(intr_11_12_reg[47:24]);
        kmat[1][2] = $signed(intr_11_12_reg[23:0]);
        kmat[2][0] = $signed(intr_20_21_reg[47:24]);
        kmat[2][1] = $signed(intr_20_21_reg[23:0]);
        kmat[2][2] = $signed(intr_22_reg);
    end

    assign busy = 1'b0;

    // ---------------- valid bits, stages 1..9 ----------------
    logic [8:0] vld_reg;
    logic       accept_next;

    assign accept_next = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[7:0], accept_next};
        end
    end

    // pixel travels alongside stages 1..9
    logic signed [PT_W-1:0] pu_reg [0:8];
    logic signed [PT_W-1:0] pv_reg [0:8];

    always_ff @(posedge clk)
    begin
        pu_reg[0] <= pixel_u;
        pv_reg[0] <= pixel_v;
        for (int s = 1; s < 9; s++)
        begin
            pu_reg[s] <= pu_reg[s-1];
            pv_reg[s] <= pv_reg[s-1];
        end
    end

    // point travels through stages 1..2, translation through stages 1..3
    logic signed [PT_W-1:0] p1_reg [0:2];
    logic signed [PT_W-1:0] p2_reg [0:2];
    logic signed [PT_W-1:0] t1_reg [0:2];
    logic signed [PT_W-1:0] t2_reg [0:2];
    logic signed [PT_W-1:0] t3_reg [0:2];

    // ---------------- stage 1: quaternion products ----------------
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] xw_reg, yw_reg, zw_reg;

    always_ff @(posedge clk)
    begin
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        zz_reg <= quat_z * quat_z;
        xy_reg <= quat_x * quat_y;
        xz_reg <= quat_x * quat_z;
        yz_reg <= quat_y * quat_z;
        xw_reg <= quat_x * quat_w;
        yw_reg <= quat_y * quat_w;
        zw_reg <= quat_z * quat_w;
        p1_reg[0] <= point_x;
        p1_reg[1] <= point_y;
        p1_reg[2] <= point_z;
        t1_reg[0] <= trans_x;
        t1_reg[1] <= trans_y;
        t1_reg[2] <= trans_z;
    end

    // ---------------- stage 2: rotation matrix, rounded to Q16 ----------------
    logic signed [35:0] rq_next [0:2][0:2];
    logic signed [23:0] rot_next [0:2][0:2];
    logic signed [23:0] rot_reg [0:2][0:2];
    logic signed [35:0] rnd_tmp;

    always_comb
    begin
        rq_next[0][0] = ONE_Q28 - ((36'(yy_reg) + 36'(zz_reg)) <<< 1);
        rq_next[0][1] = (36'(xy_reg) - 36'(zw_reg)) <<< 1;
        rq_next[0][2] = (36'(xz_reg) + 36'(yw_reg)) <<< 1;
        rq_next[1][0] = (36'(xy_reg) + 36'(zw_reg)) <<< 1;
        rq_next[1][1] = ONE_Q28 - ((36'(xx_reg) + 36'(zz_reg)) <<< 1);
        rq_next[1][2] = (36'(yz_reg) - 36'(xw_reg)) <<< 1;
        rq_next[2][0] = (36'(xz_reg) - 36'(yw_reg)) <<< 1;
        rq_next[2][1] = (36'(yz_reg) + 36'(xw_reg)) <<< 1;
        rq_next[2][2] = ONE_Q28 - ((36'(xx_reg) + 36'(yy_reg)) <<< 1);
        rnd_tmp = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // round half up: add half an LSB, then floor
                rnd_tmp = (rq_next[i][j] + 36'sd2048) >>> 12;
                rot_next[i][j] = rnd_tmp[23:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
        p2_reg  <= p1_reg;
        t2_reg  <= t1_reg;
    end

    // ---------------- stage 3: rotation products ----------------
    logic signed [55:0] rp_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rp_reg[i][j] <= rot_reg[i][j] * p2_reg[j];
            end
        end
        t3_reg <= t2_reg;
    end

    // ---------------- stage 4: add translation, Q32 ----------------
    logic signed [58:0] acc_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_reg[i] <= (59'(t3_reg[i]) <<< 16) + 59'(rp_reg[i][0])
                          + 59'(rp_reg[i][1]) + 59'(rp_reg[i][2]);
        end
    end

    // ---------------- stage 5: round to Q16 and saturate ----------------
    logic signed [58:0]   acc_rnd_next;
    logic signed [42:0]   pc_wide_next;
    logic signed [PC_W-1:0] pc_next [0:2];
    logic signed [PC_W-1:0] pc_reg [0:2];

    always_comb
    begin
        acc_rnd_next = '0;
        pc_wide_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            acc_rnd_next = (acc_reg[i] + 59'sd32768) >>> 16;
            pc_wide_next = acc_rnd_next[42:0];
            if (pc_wide_next > PC_MAX)
            begin
                pc_next[i] = PC_MAX[PC_W-1:0];
            end
            else if (pc_wide_next < PC_MIN)
            begin
                pc_next[i] = PC_MIN[PC_W-1:0];
            end
            else
            begin
                pc_next[i] = pc_wide_next[PC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg <= pc_next;
    end

    // ---------------- stage 6: intrinsic partial products ----------------
    logic signed [40:0] kpl_reg [0:2][0:2];
    logic signed [46:0] kph_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                kpl_reg[i][j] <= kmat[i][j] * $signed({1'b0, pc_reg[j][15:0]});
                kph_reg[i][j] <= kmat[i][j] * $signed(pc_reg[j][PC_W-1:16]);
            end
        end
    end

    // ---------------- stage 7: merge partial products ----------------
    logic signed [Q_W-1:0] kp_reg [0:2][0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                kp_reg[i][j] <= (Q_W'(kph_reg[i][j]) <<< 16) + Q_W'(kpl_reg[i][j]);
            end
        end
    end

    // ---------------- stage 8: row sums, 64-bit wrap ----------------
    logic signed [Q_W-1:0] q_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= kp_reg[i][0] + kp_reg[i][1] + kp_reg[i][2];
        end
    end

    // ---------------- stage 9: magnitudes and signs ----------------
    logic [Q_W-1:0] ua_reg, va_reg, da_reg;
    logic           negu_reg, negv_reg, zero_reg;

    always_ff @(posedge clk)
    begin
        ua_reg   <= q_reg[0][Q_W-1] ? Q_W'(-q_reg[0]) : q_reg[0];
        va_reg   <= q_reg[1][Q_W-1] ? Q_W'(-q_reg[1]) : q_reg[1];
        da_reg   <= q_reg[2][Q_W-1] ? Q_W'(-q_reg[2]) : q_reg[2];
        negu_reg <= q_reg[0][Q_W-1] ^ q_reg[2][Q_W-1];
        negv_reg <= q_reg[1][Q_W-1] ^ q_reg[2][Q_W-1];
        zero_reg <= (q_reg[2] == '0);
    end

    // ---------------- dividers ----------------
    logic [MAG_W-1:0] magu, magv;

    rpr_div u_div_u (
        .clk      (clk),
        .dividend (ua_reg),
        .divisor  (da_reg),
        .quotient (magu)
    );

    rpr_div u_div_v (
        .clk      (clk),
        .dividend (va_reg),
        .divisor  (da_reg),
        .quotient (magv)
    );

    // side information delayed to match the dividers
    logic                   dvld_reg [0:DIV_LAT-1];
    logic                   dzero_reg [0:DIV_LAT-1];
    logic                   dnegu_reg [0:DIV_LAT-1];
    logic                   dnegv_reg [0:DIV_LAT-1];
    logic signed [PT_W-1:0] dpu_reg [0:DIV_LAT-1];
    logic signed [PT_W-1:0] dpv_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_LAT; s++)
            begin
                dvld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            dvld_reg[0] <= vld_reg[8];
            for (int s = 1; s < DIV_LAT; s++)
            begin
                dvld_reg[s] <= dvld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dzero_reg[0] <= zero_reg;
        dnegu_reg[0] <= negu_reg;
        dnegv_reg[0] <= negv_reg;
        dpu_reg[0]   <= pu_reg[8];
        dpv_reg[0]   <= pv_reg[8];
        for (int s = 1; s < DIV_LAT; s++)
        begin
            dzero_reg[s] <= dzero_reg[s-1];
            dnegu_reg[s] <= dnegu_reg[s-1];
            dnegv_reg[s] <= dnegv_reg[s-1];
            dpu_reg[s]   <= dpu_reg[s-1];
            dpv_reg[s]   <= dpv_reg[s-1];
        end
    end

    // ---------------- output stage: sign, subtract, saturate ----------------
    logic signed [MAG_W+1:0] proju_next, projv_next, diffu_next, diffv_next;
    logic signed [PT_W-1:0]  resu_next, resv_next;
    logic signed [PT_W-1:0]  res_u_reg, res_v_reg;
    logic                    zero_depth_reg, done_reg;

    always_comb
    begin
        proju_next = dnegu_reg[DIV_LAT-1] ? -$signed({2'b00, magu}) : $signed({2'b00, magu});
        projv_next = dnegv_reg[DIV_LAT-1] ? -$signed({2'b00, magv}) : $signed({2'b00, magv});
        diffu_next = proju_next - (MAG_W+2)'(dpu_reg[DIV_LAT-1]);
        diffv_next = projv_next - (MAG_W+2)'(dpv_reg[DIV_LAT-1]);
        if (diffu_next > S32_MAX)
        begin
            resu_next = S32_MAX[PT_W-1:0];
        end
        else if (diffu_next < S32_MIN)
        begin
            resu_next = S32_MIN[PT_W-1:0];
        end
        else
        begin
            resu_next = diffu_next[PT_W-1:0];
        end
        if (diffv_next > S32_MAX)
        begin
            resv_next = S32_MAX[PT_W-1:0];
        end
        else if (diffv_next < S32_MIN)
        begin
            resv_next = S32_MIN[PT_W-1:0];
        end
        else
        begin
            resv_next = diffv_next[PT_W-1:0];
        end
        // zero depth: drop the quotient
        if (dzero_reg[DIV_LAT-1])
        begin
            resu_next = '0;
            resv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dvld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        res_u_reg      <= resu_next;
        res_v_reg      <= resv_next;
        zero_depth_reg <= dzero_reg[DIV_LAT-1];
    end

    assign done       = done_reg;
    assign res_u      = res_u_reg;
    assign res_v      = res_v_reg;
    assign zero_depth = zero_depth_reg;

endmodule

`default_nettype wire
